@@ rtl/gcrf_pkg.sv @@
// Shared constants and types for the great-circle radius filter.
package gcrf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LAT = 2'd0,
    CFG_QUERY_LON = 2'd1,
    CFG_RADIUS    = 2'd2
  } cfg_idx_e;

  // Angles in degrees Q17, wide enough for every difference the core forms
  localparam int ANG_W = 27;
  localparam logic signed [ANG_W-1:0] TURN_Q17         = 27'sd47185920;
  localparam logic signed [ANG_W-1:0] HALF_TURN_Q17    = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN_Q17 = 27'sd11796480;

  // Radians Q30
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [38:0] DEG_TO_RAD_Q44 = 39'd307041569098;
  localparam logic [18:0] D2R_HI = DEG_TO_RAD_Q44[38:20];
  localparam logic [19:0] D2R_LO = DEG_TO_RAD_Q44[19:0];

  localparam logic [13:0] EARTH_DIAM_KM = 14'd12742;

  // Taylor sine: correction terms, divisors (2k)(2k+1) and their reciprocals * 2^33
  localparam int SIN_TERMS = 9;
  localparam logic [63:0] RECIP_SCALE = 64'd1 << 33;
  localparam logic [8:0] TERM_DIV [SIN_TERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342
  };
  localparam logic [31:0] TERM_RECIP [SIN_TERMS] = '{
    32'(RECIP_SCALE / 64'd6),   32'(RECIP_SCALE / 64'd20),  32'(RECIP_SCALE / 64'd42),
    32'(RECIP_SCALE / 64'd72),  32'(RECIP_SCALE / 64'd110), 32'(RECIP_SCALE / 64'd156),
    32'(RECIP_SCALE / 64'd210), 32'(RECIP_SCALE / 64'd272), 32'(RECIP_SCALE / 64'd342)
  };

  // Pipeline depths
  localparam int SIN_LAT = 3 * SIN_TERMS + 2;
  localparam int DEG_LAT = 4 + SIN_LAT + 1;

endpackage

@@ rtl/gcrf_site_if.sv @@
// Site and result channel interfaces.
interface gcrf_site_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] site_lat;
  logic signed [24:0] site_lon;
  logic        [15:0] site_id;

  modport source (output valid, output site_lat, output site_lon, output site_id,
                  input ready);
  modport sink   (input valid, input site_lat, input site_lon, input site_id,
                  output ready);
endinterface

interface gcrf_result_if;
  logic        valid;
  logic        ready;
  logic [22:0] distance_km;
  logic        within_radius;
  logic [15:0] result_id;

  modport source (output valid, output distance_km, output within_radius,
                  output result_id, input ready);
  modport sink   (input valid, input distance_km, input within_radius,
                  input result_id, output ready);
endinterface

@@ rtl/great_circle_radius_filter_core.sv @@
// Top level of the great-circle radius filter core.
// Path from site item to result item: entry stage, degree sine units, haversine stages,
//   min(APPROX_STAGES, 31) bisection steps (24 by default) and the output register.
// Throughput: one item per cycle; each bisection step owns a fully pipelined
//   29-stage Taylor sine unit, and the whole pipeline stalls only on result backpressure.
// Reset clears the valid bits of every stage and the query and radius registers.
module great_circle_radius_filter_core #(
  parameter int APPROX_STAGES = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gcrf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gcrf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  gcrf_site_if.sink                      site_i,
  gcrf_result_if.source                  result_o
);
  import gcrf_pkg::*;

  localparam int NSTEPS = (APPROX_STAGES < 31) ? APPROX_STAGES : 31;

  typedef struct packed {
    logic [30:0] theta;
    logic [30:0] cand;
    logic        ok;
    logic [30:0] a;
    logic [15:0] id;
  } bis_side_t;

  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic        neg;
    logic [31:0] mx, my;
    logic [63:0] p;
    neg = x[31] ^ y[31];
    mx  = x[31] ? 32'(-x) : 32'(x);
    my  = y[31] ? 32'(-y) : 32'(y);
    p   = {32'd0, mx} * {32'd0, my};
    return neg ? -$signed(p[61:30]) : $signed(p[61:30]);
  endfunction

  logic adv;

  // configuration registers
  logic signed [23:0] qlat_q;
  logic signed [24:0] qlon_q;
  logic        [22:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlat_q   <= '0;
      qlon_q   <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_QUERY_LAT: qlat_q   <= cfg_wdata_i[23:0];
        CFG_QUERY_LON: qlon_q   <= cfg_wdata_i;
        CFG_RADIUS:    radius_q <= cfg_wdata_i[22:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a result waits
  logic res_valid_q;
  assign adv = !res_valid_q || result_o.ready;
  assign site_i.ready = adv;

  // entry stage: the four angles
  logic signed [ANG_W-1:0] lat1_x, lat2_x, lon1_x, lon2_x;
  logic signed [ANG_W-1:0] dlat_q, dlon_q, c1arg_q, c2arg_q;
  logic [15:0] id0_q;
  logic        v0_q;

  assign lat1_x = {{(ANG_W-24){qlat_q[23]}}, qlat_q};
  assign lat2_x = {{(ANG_W-24){site_i.site_lat[23]}}, site_i.site_lat};
  assign lon1_x = {{(ANG_W-25){qlon_q[24]}}, qlon_q};
  assign lon2_x = {{(ANG_W-25){site_i.site_lon[24]}}, site_i.site_lon};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlat_q  <= lat2_x - lat1_x;
      dlon_q  <= lon2_x - lon1_x;
      c1arg_q <= QUARTER_TURN_Q17 - (lat1_x <<< 1);
      c2arg_q <= QUARTER_TURN_Q17 - (lat2_x <<< 1);
      id0_q   <= site_i.site_id;
    end
  end

  // sines and cosines
  logic signed [31:0] s_lat, s_lon, c_lat1, c_lat2;

  gcrf_sin_deg u_sin_dlat (.clk_i(clk_i), .en_i(adv), .ang_i(dlat_q),  .sin_o(s_lat));
  gcrf_sin_deg u_sin_dlon (.clk_i(clk_i), .en_i(adv), .ang_i(dlon_q),  .sin_o(s_lon));
  gcrf_sin_deg u_cos_lat1 (.clk_i(clk_i), .en_i(adv), .ang_i(c1arg_q), .sin_o(c_lat1));
  gcrf_sin_deg u_cos_lat2 (.clk_i(clk_i), .en_i(adv), .ang_i(c2arg_q), .sin_o(c_lat2));

  logic        vd_q  [DEG_LAT];
  logic [15:0] idd_q [DEG_LAT];

  // haversine term, three stages
  logic signed [31:0] sl2_q, sn2_q, cc_q, t_q, sl2d_q;
  logic signed [32:0] a_sum;
  logic        [30:0] a_q;
  logic [15:0] idc1_q, idc2_q, idc3_q;
  logic        vc1_q, vc2_q, vc3_q;

  assign a_sum = 33'(sl2d_q) + 33'(t_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idd_q[0] <= id0_q;
      for (int i = 1; i < DEG_LAT; i++) begin
        idd_q[i] <= idd_q[i-1];
      end
      sl2_q  <= mul_q30(s_lat, s_lat);
      sn2_q  <= mul_q30(s_lon, s_lon);
      cc_q   <= mul_q30(c_lat1, c_lat2);
      idc1_q <= idd_q[DEG_LAT-1];
      t_q    <= mul_q30(sn2_q, cc_q);
      sl2d_q <= sl2_q;
      idc2_q <= idc1_q;
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > $signed({2'b00, ONE_Q30})) begin
        a_q <= ONE_Q30;
      end else begin
        a_q <= a_sum[30:0];
      end
      idc3_q <= idc2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      vc1_q <= 1'b0;
      vc2_q <= 1'b0;
      vc3_q <= 1'b0;
      for (int i = 0; i < DEG_LAT; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v0_q    <= site_i.valid;
      vd_q[0] <= v0_q;
      for (int i = 1; i < DEG_LAT; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
      vc1_q <= vd_q[DEG_LAT-1];
      vc2_q <= vc1_q;
      vc3_q <= vc2_q;
    end
  end

  // arcsine of the square root by bisection, one pipelined step per bit
  logic        bv  [NSTEPS+1];
  logic [30:0] bth [NSTEPS+1];
  logic [30:0] ba  [NSTEPS+1];
  logic [15:0] bid [NSTEPS+1];

  assign bv[0]  = vc3_q;
  assign bth[0] = '0;
  assign ba[0]  = a_q;
  assign bid[0] = idc3_q;

  for (genvar j = 0; j < NSTEPS; j++) begin : g_step
    localparam logic [30:0] STEP_BIT = 31'd1 << (30 - j);

    logic [30:0] cand;
    logic        cand_ok;
    logic [30:0] s_mag;
    logic [61:0] s_sq;
    bis_side_t   side_q [SIN_LAT];
    bis_side_t   side_sq_q;
    logic        v_line_q [SIN_LAT];
    logic        v_sq_q, v_out_q;
    logic [31:0] sq_q;
    logic [30:0] th_q, a_out_q;
    logic [15:0] id_out_q;

    assign cand    = bth[j] | STEP_BIT;
    assign cand_ok = (cand <= HALF_PI_Q30);
    assign s_sq    = {31'd0, s_mag} * {31'd0, s_mag};

    gcrf_sin_rad u_sin_rad (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (cand),
      .sin_o (s_mag)
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[0] <= '{theta: bth[j], cand: cand, ok: cand_ok, a: ba[j], id: bid[j]};
        for (int i = 1; i < SIN_LAT; i++) begin
          side_q[i] <= side_q[i-1];
        end
        sq_q      <= s_sq[61:30];
        side_sq_q <= side_q[SIN_LAT-1];
        th_q      <= (side_sq_q.ok && (sq_q <= {1'b0, side_sq_q.a})) ? side_sq_q.cand
                                                                     : side_sq_q.theta;
        a_out_q   <= side_sq_q.a;
        id_out_q  <= side_sq_q.id;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < SIN_LAT; i++) begin
          v_line_q[i] <= 1'b0;
        end
        v_sq_q  <= 1'b0;
        v_out_q <= 1'b0;
      end else if (adv) begin
        v_line_q[0] <= bv[j];
        for (int i = 1; i < SIN_LAT; i++) begin
          v_line_q[i] <= v_line_q[i-1];
        end
        v_sq_q  <= v_line_q[SIN_LAT-1];
        v_out_q <= v_sq_q;
      end
    end

    assign bv[j+1]  = v_out_q;
    assign bth[j+1] = th_q;
    assign ba[j+1]  = a_out_q;
    assign bid[j+1] = id_out_q;
  end

  // distance, radius test and output register
  logic [44:0] dist_full;
  logic [22:0] dist_d, dist_q;
  logic        within_q;
  logic [15:0] res_id_q;

  assign dist_full = {31'd0, EARTH_DIAM_KM} * {14'd0, bth[NSTEPS]};
  assign dist_d    = dist_full[44:22];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q   <= dist_d;
      within_q <= (dist_d < radius_q);
      res_id_q <= bid[NSTEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= bv[NSTEPS];
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.distance_km   = dist_q;
  assign result_o.within_radius = within_q;
  assign result_o.result_id     = res_id_q;

  // an accepted site enters the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    site_i.valid && site_i.ready |=> v0_q)
    else $error("accepted site item did not enter the pipeline");

  // bisection never leaves the quarter circle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bv[NSTEPS] |-> bth[NSTEPS] <= HALF_PI_Q30)
    else $error("bisection angle beyond a quarter circle");

  // distances stay within half the circumference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.distance_km <= 23'd5123863)
    else $error("distance beyond half the circumference");

  // a zero radius accepts nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.within_radius |-> radius_q != '0)
    else $error("site flagged inside a zero radius");

endmodule

@@ rtl/gcrf_sin_rad.sv @@
// Pipelined Taylor sine of a radian magnitude in Q30, clamped to [0, 1].
module gcrf_sin_rad (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] x_i,
  output logic [30:0] sin_o
);
  import gcrf_pkg::*;

  localparam int N = SIN_TERMS;

  // stage-C outputs; index 0 is the entry stage
  logic        [31:0] tc_q  [N+1];
  logic signed [33:0] sc_q  [N+1];
  logic        [31:0] x2c_q [N];
  // stage A: product term*x2, running sum
  logic        [32:0] pa_q  [N];
  logic signed [33:0] sa_q  [N];
  logic        [31:0] x2a_q [N];
  // stage B: estimated quotient
  logic        [32:0] pb_q  [N];
  logic        [30:0] qb_q  [N];
  logic signed [33:0] sb_q  [N];
  logic        [31:0] x2b_q [N];

  logic        [61:0] x_sq;
  logic        [63:0] prod_a [N];
  logic        [63:0] prod_b [N];
  logic signed [33:0] sum_a  [N];
  logic        [39:0] qd_c   [N];
  logic        [39:0] rem_c  [N];
  logic        [31:0] term_c [N];
  logic signed [33:0] sum_f;
  logic        [30:0] sin_d;
  logic [30:0] sin_q;

  assign x_sq = {31'd0, x_i} * {31'd0, x_i};

  // per-term datapath
  always_comb begin
    for (int k = 0; k < N; k++) begin
      prod_a[k] = {32'd0, tc_q[k]} * {32'd0, x2c_q[k]};
      if ((k & 1) == 0) begin
        sum_a[k] = sc_q[k] + $signed({2'b00, tc_q[k]});
      end else begin
        sum_a[k] = sc_q[k] - $signed({2'b00, tc_q[k]});
      end
      prod_b[k] = {31'd0, pa_q[k]} * {32'd0, TERM_RECIP[k]};
      qd_c[k]   = {9'd0, qb_q[k]} * {31'd0, TERM_DIV[k]};
      rem_c[k]  = {7'd0, pb_q[k]} - qd_c[k];
      term_c[k] = {1'b0, qb_q[k]} + ((rem_c[k] >= {31'd0, TERM_DIV[k]}) ? 32'd1 : 32'd0);
    end
  end

  // last term folded in, then clamp
  always_comb begin
    if ((N & 1) == 0) begin
      sum_f = sc_q[N] + $signed({2'b00, tc_q[N]});
    end else begin
      sum_f = sc_q[N] - $signed({2'b00, tc_q[N]});
    end
    if (sum_f < 0) begin
      sin_d = '0;
    end else if (sum_f > $signed({3'b000, ONE_Q30})) begin
      sin_d = ONE_Q30;
    end else begin
      sin_d = sum_f[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tc_q[0]  <= {1'b0, x_i};
      sc_q[0]  <= '0;
      x2c_q[0] <= x_sq[61:30];
      for (int k = 0; k < N; k++) begin
        pa_q[k]  <= prod_a[k][62:30];
        sa_q[k]  <= sum_a[k];
        x2a_q[k] <= x2c_q[k];
        pb_q[k]  <= pa_q[k];
        qb_q[k]  <= prod_b[k][63:33];
        sb_q[k]  <= sa_q[k];
        x2b_q[k] <= x2a_q[k];
        tc_q[k+1] <= term_c[k];
        sc_q[k+1] <= sb_q[k];
        if (k < N - 1) begin
          x2c_q[k+1] <= x2b_q[k];
        end
      end
      sin_q <= sin_d;
    end
  end

  assign sin_o = sin_q;

endmodule

@@ rtl/gcrf_sin_deg.sv @@
// Pipelined signed sine of an angle in degrees Q17, result in Q30.
module gcrf_sin_deg (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [gcrf_pkg::ANG_W-1:0]  ang_i,
  output logic signed [31:0]                 sin_o
);
  import gcrf_pkg::*;

  logic signed [ANG_W-1:0] wrap_d, wrap_q;
  logic signed [ANG_W-1:0] fold;
  logic        [ANG_W-1:0] fold_abs;
  logic        [23:0]      mag_q;
  logic                    neg1_q, neg2_q, neg3_q;
  logic        [42:0]      pp_hi_q;
  logic        [43:0]      pp_lo_q;
  logic        [63:0]      rad_full;
  logic        [30:0]      rad_d, rad_q;
  logic                    neg_line_q [SIN_LAT];
  logic        [30:0]      sin_mag;
  logic signed [31:0]      sin_q;

  // wrap into [-180, 180]
  always_comb begin
    if (ang_i > HALF_TURN_Q17) begin
      wrap_d = ang_i - TURN_Q17;
    end else if (ang_i < -HALF_TURN_Q17) begin
      wrap_d = ang_i + TURN_Q17;
    end else begin
      wrap_d = ang_i;
    end
  end

  // fold into [-90, 90] and split sign and magnitude
  always_comb begin
    if (wrap_q > QUARTER_TURN_Q17) begin
      fold = HALF_TURN_Q17 - wrap_q;
    end else if (wrap_q < -QUARTER_TURN_Q17) begin
      fold = -HALF_TURN_Q17 - wrap_q;
    end else begin
      fold = wrap_q;
    end
    fold_abs = fold[ANG_W-1] ? ANG_W'(-fold) : ANG_W'(fold);
  end

  // degrees to radians, product recombined from two partial products
  assign rad_full = {1'b0, pp_hi_q, 20'd0} + {20'd0, pp_lo_q};
  assign rad_d = (rad_full[63:31] > {2'b00, HALF_PI_Q30}) ? HALF_PI_Q30 : rad_full[61:31];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrap_q  <= wrap_d;
      mag_q   <= fold_abs[23:0];
      neg1_q  <= fold[ANG_W-1];
      pp_hi_q <= {19'd0, mag_q} * {24'd0, D2R_HI};
      pp_lo_q <= {20'd0, mag_q} * {24'd0, D2R_LO};
      neg2_q  <= neg1_q;
      rad_q   <= rad_d;
      neg3_q  <= neg2_q;
      neg_line_q[0] <= neg3_q;
      for (int i = 1; i < SIN_LAT; i++) begin
        neg_line_q[i] <= neg_line_q[i-1];
      end
      sin_q <= neg_line_q[SIN_LAT-1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    end
  end

  gcrf_sin_rad u_sin_rad (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (rad_q),
    .sin_o (sin_mag)
  );

  assign sin_o = sin_q;

endmodule

@@ sim/great_circle_radius_filter_core_tb.sv @@
// Self-checking testbench for the great-circle radius filter core.
`timescale 1ns / 1ps

module great_circle_radius_filter_core_tb;
  import gcrf_pkg::*;

  localparam int    BISECT_STEPS = 24;
  localparam int    PIPE_CYCLES  = 39 + 31 * BISECT_STEPS;
  localparam int    LONG_HOLD    = 2000;
  localparam longint LAT_MAX     = 5898240;
  localparam longint LON_MAX     = 11796480;

  typedef struct packed {
    logic [22:0] dist_km;
    logic        in_radius;
    logic [15:0] id;
  } site_result_t;

  typedef struct {
    logic signed [23:0] lat;
    logic signed [24:0] lon;
    logic        [15:0] id;
    bit                 known;
    logic        [22:0] dist_km;
    logic               in_radius;
  } site_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  gcrf_site_if   site_bus ();
  gcrf_result_if res_bus ();

  great_circle_radius_filter_core #(.APPROX_STAGES(BISECT_STEPS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .site_i      (site_bus),
    .result_o    (res_bus)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the configuration
  logic signed [23:0] qry_lat = '0;
  logic signed [24:0] qry_lon = '0;
  logic        [22:0] radius_q8 = '0;

  site_result_t pending_results[$];
  int  mismatches = 0;
  int  sites_sent = 0;
  int  results_seen = 0;
  int  inside_seen = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  // Taylor sine of a Q30 radian magnitude, clamped to [0, 1]
  function automatic longint taylor_sin(longint unsigned x);
    longint unsigned x2, term;
    longint sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= SIN_TERMS; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return sum;
  endfunction

  // Sine of a Q17 degree angle, any value
  function automatic longint sin_deg(longint a);
    longint r;
    longint unsigned mag, rad;
    bit neg;
    r = a % longint'(TURN_Q17);
    if (r > longint'(HALF_TURN_Q17)) r -= longint'(TURN_Q17);
    if (r < -longint'(HALF_TURN_Q17)) r += longint'(TURN_Q17);
    if (r > longint'(QUARTER_TURN_Q17)) r = longint'(HALF_TURN_Q17) - r;
    if (r < -longint'(QUARTER_TURN_Q17)) r = -longint'(HALF_TURN_Q17) - r;
    neg = r < 0;
    mag = neg ? -r : r;
    rad = (mag * longint'(DEG_TO_RAD_Q44)) >> 31;
    if (rad > longint'(HALF_PI_Q30)) rad = longint'(HALF_PI_Q30);
    return neg ? -taylor_sin(rad) : taylor_sin(rad);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    longint unsigned ma, mb;
    longint p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = longint'((ma * mb) >> 30);
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  // Haversine distance and radius test for one site
  function automatic site_result_t predict_distance(logic signed [23:0] lat,
                                                    logic signed [24:0] lon,
                                                    logic [15:0] id);
    longint lat1, lat2, s_lat, s_lon, cc, hav, s;
    longint unsigned theta, cand, dist_scaled;
    site_result_t res;
    lat1 = longint'(qry_lat);
    lat2 = longint'(lat);
    s_lat = sin_deg(lat2 - lat1);
    s_lon = sin_deg(longint'(lon) - longint'(qry_lon));
    cc = mul_q30(sin_deg(longint'(QUARTER_TURN_Q17) - 2 * lat1),
                 sin_deg(longint'(QUARTER_TURN_Q17) - 2 * lat2));
    hav = mul_q30(s_lat, s_lat) + mul_q30(mul_q30(s_lon, s_lon), cc);
    if (hav < 0) hav = 0;
    if (hav > longint'(ONE_Q30)) hav = longint'(ONE_Q30);
    theta = 0;
    for (int k = 0; k < BISECT_STEPS && k < 31; k++) begin
      cand = theta + (64'd1 << (30 - k));
      if (cand <= longint'(HALF_PI_Q30)) begin
        s = taylor_sin(cand);
        if (mul_q30(s, s) <= hav) theta = cand;
      end
    end
    dist_scaled = (longint'(EARTH_DIAM_KM) * theta) >> 22;
    res.dist_km = dist_scaled[22:0];
    res.in_radius = res.dist_km < radius_q8;
    res.id = id;
    return res;
  endfunction

  // Result monitor
  always @(posedge clk_i) begin
    site_result_t want;
    if (res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (res_bus.within_radius) inside_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result id=%0d dist=%0d",
                                       res_bus.result_id, res_bus.distance_km);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.distance_km !== want.dist_km ||
            res_bus.within_radius !== want.in_radius ||
            res_bus.result_id !== want.id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp dist=%0d in=%0d id=%0d, got dist=%0d in=%0d id=%0d",
                     want.dist_km, want.in_radius, want.id, res_bus.distance_km,
                     res_bus.within_radius, res_bus.result_id);
        end
      end
    end
  end

  // Result ready: random stall bursts, one long hold once results flow
  int hold_cnt = 0;
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_bus.ready <= 1'b0;
      end else if (hold_req && !hold_done && res_bus.valid) begin
        hold_done = 1'b1;
        hold_cnt = LONG_HOLD - 1;
        res_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_cnt = $urandom_range(1, 11) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one site item and record its expected result on acceptance
  task automatic send_site(logic signed [23:0] lat, logic signed [24:0] lon,
                           logic [15:0] id, bit known, logic [22:0] exp_dist,
                           logic exp_in);
    site_result_t res;
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      site_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    site_bus.valid    <= 1'b1;
    site_bus.site_lat <= lat;
    site_bus.site_lon <= lon;
    site_bus.site_id  <= id;
    do @(posedge clk_i); while (!site_bus.ready);
    res = predict_distance(lat, lon, id);
    if (known) begin
      res.dist_km = exp_dist;
      res.in_radius = exp_in;
    end
    pending_results = {pending_results, res};
    sites_sent++;
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain_results();
    site_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES + 20) @(posedge clk_i);
  endtask

  task automatic write_config(logic signed [23:0] lat, logic signed [24:0] lon,
                              logic [22:0] radius);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_QUERY_LAT;
    cfg_wdata_i <= 25'(lat);
    @(posedge clk_i);
    cfg_index_i <= CFG_QUERY_LON;
    cfg_wdata_i <= lon;
    @(posedge clk_i);
    cfg_index_i <= CFG_RADIUS;
    cfg_wdata_i <= 25'(radius);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    qry_lat = lat;
    qry_lon = lon;
    radius_q8 = radius;
  endtask

  // Random site: mostly legal, some near the query point, some raw bit patterns
  task automatic send_random_site();
    logic signed [23:0] lat;
    logic signed [24:0] lon;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      lat = 24'($urandom_range(0, 2 * LAT_MAX) - LAT_MAX);
      lon = 25'($urandom_range(0, 2 * LON_MAX) - LON_MAX);
    end else if (pick < 8) begin
      lat = qry_lat + 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      lon = qry_lon + 25'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    end else begin
      lat = 24'($urandom);
      lon = 25'($urandom);
    end
    send_site(lat, lon, 16'($urandom), 1'b0, '0, 1'b0);
  endtask

  // Coincident points settle at the largest angle whose squared sine is still zero: 99/256 km
  site_row_t corner_rows[15] = '{
    '{24'sd0, 25'sd0, 16'd0, 1'b1, 23'd99, 1'b0},
    '{24'sd0, 25'sd0, 16'hffff, 1'b1, 23'd99, 1'b0},
    '{24'sd5898240, 25'sd0, 16'd2, 1'b0, 23'd0, 1'b0},
    '{-24'sd5898240, 25'sd0, 16'd3, 1'b0, 23'd0, 1'b0},
    '{24'sd0, 25'sd11796480, 16'd4, 1'b0, 23'd0, 1'b0},
    '{24'sd0, -25'sd11796480, 16'd5, 1'b0, 23'd0, 1'b0},
    '{24'sd5898240, 25'sd11796480, 16'd6, 1'b0, 23'd0, 1'b0},
    '{-24'sd5898240, -25'sd11796480, 16'd7, 1'b0, 23'd0, 1'b0},
    '{24'sh7fffff, 25'sd0, 16'd8, 1'b0, 23'd0, 1'b0},
    '{24'sh800000, 25'sd0, 16'd9, 1'b0, 23'd0, 1'b0},
    '{24'sd0, 25'sh0ffffff, 16'd10, 1'b0, 23'd0, 1'b0},
    '{24'sd0, 25'sh1000000, 16'd11, 1'b0, 23'd0, 1'b0},
    '{24'sh7fffff, 25'sh1000000, 16'h8000, 1'b0, 23'd0, 1'b0},
    '{24'sd2949120, 25'sd5898240, 16'h5555, 1'b0, 23'd0, 1'b0},
    '{-24'sd65536, 25'sd65536, 16'haaaa, 1'b0, 23'd0, 1'b0}
  };

  // Main stimulus sequence
  initial begin
    site_bus.valid = 1'b0;
    site_bus.site_lat = '0;
    site_bus.site_lon = '0;
    site_bus.site_id = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: query at origin, zero radius
    foreach (corner_rows[i])
      send_site(corner_rows[i].lat, corner_rows[i].lon, corner_rows[i].id,
                corner_rows[i].known, corner_rows[i].dist_km, corner_rows[i].in_radius);
    drain_results();

    // Query at a pole, largest radius, long result stall once results flow
    write_config(24'sd5898240, -25'sd11796480, 23'h7fffff);
    hold_req = 1'b1;
    repeat (600) send_random_site();
    drain_results();

    // Opposite extremes, mid radius
    write_config(-24'sd5898240, 25'sd11796480, 23'd768000);
    repeat (300) send_random_site();
    drain_results();

    // Random query, out-of-range patterns allowed, no idling
    write_config(24'($urandom), 25'($urandom), 23'd2560000);
    calm = 1'b1;
    repeat (300) send_random_site();
    drain_results();

    $display("Sent %0d sites over four query/radius settings; %0d results, %0d inside radius.",
             sites_sent, results_seen, inside_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #12000000;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
